### rtl/aes_pkg.sv
package aes_pkg;

   typedef struct packed {
      logic valid;
      logic op;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      MODE_FIRST,
      MODE_MID,
      MODE_LAST,
      MODE_PASS
   } cell_mode_type;

   localparam int DEFAULT_MAX_ROUNDS = 14;

   localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
   localparam logic [2:0] REG_KEY_0      = 3'd1;
   localparam logic [2:0] REG_KEY_1      = 3'd2;
   localparam logic [2:0] REG_KEY_2      = 3'd3;
   localparam logic [2:0] REG_KEY_3      = 3'd4;

   localparam logic [1:0] KEY_LEN_128 = 2'd0;
   localparam logic [1:0] KEY_LEN_192 = 2'd1;
   localparam logic [1:0] KEY_LEN_256 = 2'd2;

   localparam logic [7:0] GF_POLY = 8'h1b;

   localparam logic [2047:0] SBOX_FWD = {
      128'h637c777bf26b6fc53001672bfed7ab76,
      128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115,
      128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84,
      128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8,
      128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973,
      128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479,
      128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
      128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df,
      128'h8ca1890dbfe6426841992d0fb054bb16
   };

   localparam logic [2047:0] SBOX_INV = {
      128'h52096ad53036a538bf40a39e81f3d7fb,
      128'h7ce339829b2fff87348e4344c4dee9cb,
      128'h547b9432a6c2233dee4c950b42fac34e,
      128'h082ea16628d924b2765ba2496d8bd125,
      128'h72f8f66486689816d4a45ccc5d65b692,
      128'h6c704850fdedb9da5e154657a78d9d84,
      128'h90d8ab008cbcd30af7e45805b8b34506,
      128'hd02c1e8fca3f0f02c1afbd0301138a6b,
      128'h3a9111414f67dcea97f2cfcef0b4e673,
      128'h96ac7422e7ad3585e2f937e81c75df6e,
      128'h47f11a711d29c5896fb7620eaa18be1b,
      128'hfc563e4bc6d279209adbc0fe78cd5af4,
      128'h1fdda8338807c731b11210592780ec5f,
      128'h60517fa919b54a0d2de57a9f93c99cef,
      128'ha0e03b4dae2af5b0c8ebbb3c83539961,
      128'h172b047eba77d626e169146355210c7d
   };

   function automatic logic [7:0] sbox(input logic [7:0] b);
      return SBOX_FWD[{~b, 3'b111} -: 8];
   endfunction

   function automatic logic [7:0] sbox_inv(input logic [7:0] b);
      return SBOX_INV[{~b, 3'b111} -: 8];
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd0: r = 8'h01;
         4'd1: r = 8'h02;
         4'd2: r = 8'h04;
         4'd3: r = 8'h08;
         4'd4: r = 8'h10;
         4'd5: r = 8'h20;
         4'd6: r = 8'h40;
         4'd7: r = 8'h80;
         4'd8: r = 8'h1b;
         4'd9: r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
      logic [127:0] r;
      logic [7:0] b;
      for (int i = 0; i < 16; i++) begin
         b = s[127-8*i -: 8];
         r[127-8*i -: 8] = inv ? sbox_inv(b) : sbox(b);
      end
      return r;
   endfunction

   function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
      logic [127:0] r;
      int src;
      for (int row = 0; row < 4; row++) begin
         for (int col = 0; col < 4; col++) begin
            src = inv ? ((col + 4 - row) & 3) : ((col + row) & 3);
            r[127-8*(row+4*col) -: 8] = s[127-8*(row+4*src) -: 8];
         end
      end
      return r;
   endfunction

   function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
      logic [127:0] r;
      logic [7:0] a [4];
      logic [7:0] x2 [4];
      logic [7:0] x4 [4];
      logic [7:0] x8 [4];
      logic [7:0] m9, m11, m13, m14, m2, m3;
      for (int col = 0; col < 4; col++) begin
         for (int j = 0; j < 4; j++) begin
            a[j]  = s[127-8*(4*col+j) -: 8];
            x2[j] = xtime(a[j]);
            x4[j] = xtime(x2[j]);
            x8[j] = xtime(x4[j]);
         end
         for (int row = 0; row < 4; row++) begin
            m2  = x2[row];
            m3  = x2[(row+1)&3] ^ a[(row+1)&3];
            m14 = x8[row] ^ x4[row] ^ x2[row];
            m11 = x8[(row+1)&3] ^ x2[(row+1)&3] ^ a[(row+1)&3];
            m13 = x8[(row+2)&3] ^ x4[(row+2)&3] ^ a[(row+2)&3];
            m9  = x8[(row+3)&3] ^ a[(row+3)&3];
            r[127-8*(4*col+row) -: 8] = inv ? (m14 ^ m11 ^ m13 ^ m9)
                                            : (m2 ^ m3 ^ a[(row+2)&3] ^ a[(row+3)&3]);
         end
      end
      return r;
   endfunction

endpackage

### rtl/aes_block_cipher_core.sv
// aes block cipher core: aes-128/192/256 encrypt and decrypt, one block per cycle unless stalled
//
// config: apb-style port (psel, penable, pwrite, paddr, pwdata, prdata, pready),
// 64-bit registers at byte address 8*i: key_length, key_0 .. key_3. every write
// to one of them restarts the key schedule, which produces one round key word
// per cycle, 4*(nr+1) words in all. req_stall stays high while the schedule runs.
// request channel: req_valid/req_stall carry op (0 encrypt, 1 decrypt) and the
// 128-bit block; response channel: rsp_valid/rsp_stall carry the result.
// a transfer happens when valid is high and stall is low.
// the datapath is a chain of MAX_ROUNDS+1 round cells, one round per cell, for
// every key size; the throughput is one block per cycle while neither channel
// nor the key schedule stalls; cells past the last round pass data on.
// when rsp_stall holds a result, empty cells behind it still fill, and the
// request side stalls only once the chain is full.
// reset is synchronous: it empties the chain, sets key_length to 256 bits and
// clears the key registers; round keys are only valid after a key write.
module aes_block_cipher_core import aes_pkg::*; #(
   parameter int MAX_ROUNDS = DEFAULT_MAX_ROUNDS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_op,
   input  logic [63:0]  req_block_high,
   input  logic [63:0]  req_block_low,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [63:0]  rsp_result_high,
   output logic [63:0]  rsp_result_low,
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [5:0]   paddr,
   input  logic [63:0]  pwdata,
   output logic [63:0]  prdata,
   output logic         pready
);

   localparam int RW = $clog2(MAX_ROUNDS + 1);
   localparam int L0 = (10 < MAX_ROUNDS) ? 10 : MAX_ROUNDS;
   localparam int L1 = (12 < MAX_ROUNDS) ? 12 : MAX_ROUNDS;
   localparam int L2 = (14 < MAX_ROUNDS) ? 14 : MAX_ROUNDS;

   logic [1:0]    key_length_ff;
   logic [63:0]   key_ff [4];
   logic          start_ff;
   logic          cfg_wr;
   logic [2:0]    reg_idx;
   logic          exp_busy;
   logic [RW-1:0] nr;
   logic [127:0]  rkeys [MAX_ROUNDS+1];

   cell_ctl_type  ctl [MAX_ROUNDS+2];
   logic [127:0]  st [MAX_ROUNDS+2];
   logic          adv [MAX_ROUNDS+2];

   assign pready  = 1'b1;
   assign reg_idx = paddr[5:3];
   assign cfg_wr  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= KEY_LEN_256;
         for (int j = 0; j < 4; j++) begin
            key_ff[j] <= '0;
         end
         start_ff <= 1'b0;
      end else begin
         start_ff <= cfg_wr && (reg_idx inside {[REG_KEY_LENGTH:REG_KEY_3]});
         if (cfg_wr) begin
            case (reg_idx)
               REG_KEY_LENGTH: key_length_ff <= pwdata[1:0];
               REG_KEY_0:      key_ff[0] <= pwdata;
               REG_KEY_1:      key_ff[1] <= pwdata;
               REG_KEY_2:      key_ff[2] <= pwdata;
               REG_KEY_3:      key_ff[3] <= pwdata;
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (reg_idx)
         REG_KEY_LENGTH: prdata = {62'h0, key_length_ff};
         REG_KEY_0:      prdata = key_ff[0];
         REG_KEY_1:      prdata = key_ff[1];
         REG_KEY_2:      prdata = key_ff[2];
         REG_KEY_3:      prdata = key_ff[3];
         default:        prdata = '0;
      endcase
      case (key_length_ff)
         KEY_LEN_128: nr = RW'(L0);
         KEY_LEN_192: nr = RW'(L1);
         default:     nr = RW'(L2);
      endcase
   end

   aes_key_sched #(.MAX_ROUNDS(MAX_ROUNDS)) u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .start      (start_ff),
      .key_length (key_length_ff),
      .nr         (nr),
      .key        (key_ff),
      .busy       (exp_busy),
      .rkeys      (rkeys)
   );

   assign ctl[0].valid = req_valid && !start_ff && !exp_busy;
   assign ctl[0].op    = req_op;
   assign st[0]        = {req_block_high, req_block_low};
   assign adv[MAX_ROUNDS+1] = !rsp_stall;
   assign req_stall    = !adv[0] || start_ff || exp_busy;

   for (genvar k = 0; k <= MAX_ROUNDS; k++) begin : g_cell
      localparam int D0 = (k <= L0) ? L0 - k : 0;
      localparam int D1 = (k <= L1) ? L1 - k : 0;
      localparam int D2 = (k <= L2) ? L2 - k : 0;
      cell_mode_type mode;
      logic [127:0]  rk_dec, rk;

      assign adv[k] = !ctl[k+1].valid || adv[k+1];

      always_comb begin
         if (k == 0) begin
            mode = MODE_FIRST;
         end else if (RW'(k) < nr) begin
            mode = MODE_MID;
         end else if (RW'(k) == nr) begin
            mode = MODE_LAST;
         end else begin
            mode = MODE_PASS;
         end
         case (key_length_ff)
            KEY_LEN_128: rk_dec = rkeys[D0];
            KEY_LEN_192: rk_dec = rkeys[D1];
            default:     rk_dec = rkeys[D2];
         endcase
         rk = ctl[k].op ? rk_dec : rkeys[k];
      end

      aes_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv[k]),
         .mode      (mode),
         .ctl_in    (ctl[k]),
         .state_in  (st[k]),
         .rkey      (rk),
         .ctl_out   (ctl[k+1]),
         .state_out (st[k+1])
      );
   end

   assign rsp_valid       = ctl[MAX_ROUNDS+1].valid;
   assign rsp_result_high = st[MAX_ROUNDS+1][127:64];
   assign rsp_result_low  = st[MAX_ROUNDS+1][63:0];

`ifndef ASSERT_OFF
   a_no_transfer_in_expand: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (!exp_busy && !start_ff))
      else $error("request transfer while key schedule runs");

   a_key_write_restarts: assert property (@(posedge clock) disable iff (reset)
      (cfg_wr && reg_idx == REG_KEY_0) |=> (start_ff && req_stall))
      else $error("key write did not restart key schedule");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      $rose(exp_busy) |-> $past(start_ff))
      else $error("key schedule started without a register write");

   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start_ff |=> exp_busy)
      else $error("key schedule not busy after start");
`endif

endmodule

### rtl/aes_cell.sv
module aes_cell import aes_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          adv,
   input  cell_mode_type mode,
   input  cell_ctl_type  ctl_in,
   input  logic [127:0]  state_in,
   input  logic [127:0]  rkey,
   output cell_ctl_type  ctl_out,
   output logic [127:0]  state_out
);

   cell_ctl_type ctl_ff;
   logic [127:0] state_ff, state_in_nx;
   logic [127:0] enc_sr, enc_mid, enc_last, dec_ak, dec_mid;
   logic [127:0] state_ff_in;

   assign state_in_nx = state_in;

   always_comb begin
      enc_sr   = shift_rows(sub_bytes(state_in, 1'b0), 1'b0);
      enc_mid  = mix_columns(enc_sr, 1'b0) ^ rkey;
      enc_last = enc_sr ^ rkey;
      dec_ak   = sub_bytes(shift_rows(state_in, 1'b1), 1'b1) ^ rkey;
      dec_mid  = mix_columns(dec_ak, 1'b1);
      case (mode)
         MODE_FIRST: state_ff_in = state_in_nx ^ rkey;
         MODE_MID:   state_ff_in = ctl_in.op ? dec_mid : enc_mid;
         MODE_LAST:  state_ff_in = ctl_in.op ? dec_ak : enc_last;
         MODE_PASS:  state_ff_in = state_in_nx;
         default:    state_ff_in = state_in_nx;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         state_ff <= state_ff_in;
      end
   end

   assign ctl_out   = ctl_ff;
   assign state_out = state_ff;

endmodule

### rtl/aes_key_sched.sv
module aes_key_sched import aes_pkg::*; #(
   parameter int MAX_ROUNDS = DEFAULT_MAX_ROUNDS,
   localparam int RW = $clog2(MAX_ROUNDS + 1),
   localparam int IW = RW + 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [1:0]    key_length,
   input  logic [RW-1:0] nr,
   input  logic [63:0]   key [4],
   output logic          busy,
   output logic [127:0]  rkeys [MAX_ROUNDS+1]
);

   logic          busy_ff, busy_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [2:0]    pos_ff, pos_in;
   logic [3:0]    rc_ff, rc_in;
   logic [31:0]   win_ff [8];
   logic [31:0]   rk_ff [MAX_ROUNDS+1][4];
   logic [2:0]    nk_m1;
   logic [31:0]   tmp, far, word;
   logic          expand;
   logic [63:0]   kreg;

   always_comb begin
      case (key_length)
         KEY_LEN_128: nk_m1 = 3'd3;
         KEY_LEN_192: nk_m1 = 3'd5;
         default:     nk_m1 = 3'd7;
      endcase
      case (key_length)
         KEY_LEN_128: far = win_ff[3];
         KEY_LEN_192: far = win_ff[5];
         default:     far = win_ff[7];
      endcase
      expand = idx_ff > IW'(nk_m1);
      kreg   = key[idx_ff[2:1]];
      tmp    = win_ff[0];
      if (pos_ff == 3'd0) begin
         tmp = sub_word({win_ff[0][23:0], win_ff[0][31:24]}) ^ {rcon(rc_ff), 24'h0};
      end else if (key_length[1] && pos_ff == 3'd4) begin
         tmp = sub_word(win_ff[0]);
      end
      word = expand ? (far ^ tmp) : (idx_ff[0] ? kreg[31:0] : kreg[63:32]);

      busy_in = busy_ff;
      idx_in  = idx_ff;
      pos_in  = pos_ff;
      rc_in   = rc_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
         pos_in  = '0;
         rc_in   = '0;
      end else if (busy_ff) begin
         idx_in = idx_ff + IW'(1);
         pos_in = (pos_ff == nk_m1) ? 3'd0 : pos_ff + 3'd1;
         if (expand && pos_ff == 3'd0) begin
            rc_in = (rc_ff == 4'd9) ? 4'd0 : rc_ff + 4'd1;
         end
         if (idx_ff == {nr, 2'b11}) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         pos_ff  <= '0;
         rc_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         pos_ff  <= pos_in;
         rc_ff   <= rc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff && !start) begin
         win_ff[0] <= word;
         for (int j = 1; j < 8; j++) begin
            win_ff[j] <= win_ff[j-1];
         end
         rk_ff[idx_ff[IW-1:2]][idx_ff[1:0]] <= word;
      end
   end

   for (genvar r = 0; r <= MAX_ROUNDS; r++) begin : g_rk
      assign rkeys[r] = {rk_ff[r][0], rk_ff[r][1], rk_ff[r][2], rk_ff[r][3]};
   end

   assign busy = busy_ff;

endmodule
